FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: src/yrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_pkg
// Types and constants for the YCbCr to RGB pixel converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int ACC_W = 27;  // holds Y*65536 + rounding + largest chroma term

  localparam logic signed [17:0] K_R_CR = 18'sd92094;
  localparam logic signed [17:0] K_G_CB = 18'sd22527;
  localparam logic signed [17:0] K_G_CR = 18'sd46819;
  localparam logic signed [17:0] K_B_CB = 18'sd115992;

  localparam logic [8:0]  CHROMA_OFFSET = 9'd128;
  localparam logic [15:0] ROUND_HALF    = 16'h8000;

  localparam logic [2:0] BYTES_32 = 3'd4;
  localparam logic [2:0] BYTES_24 = 3'd3;

  typedef enum logic [1:0] {
    FMT_ARGB32 = 2'd0,
    FMT_ABGR32 = 2'd1,
    FMT_RGB24  = 2'd2,
    FMT_BGR24  = 2'd3
  } pixel_format_t;

  // Floor the signed 11.16 sum to an integer and clamp to 0..255.
  function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-17:0] whole;
    begin
      whole = acc[ACC_W-1:16];
      if (whole < 0) begin
        clamp_channel = 8'd0;
      end else if (whole > 255) begin
        clamp_channel = 8'd255;
      end else begin
        clamp_channel = whole[7:0];
      end
    end
  endfunction

endpackage

FILE: src/ycbcr_to_rgb_pixel_convert_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_convert_top
// YCbCr to packed RGB pixel converter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel item: luma, Cb, Cr, alpha bytes in tdata.
//   m_axis returns one packed pixel per item: the 32-bit word plus the
//   count of valid bytes (4 for ARGB/ABGR, 3 for the 24-bit forms).
//   cfg_we/cfg_wdata set the pixel format; write it only while idle.
// Timing:
//   Two register stages: an input register, then the color matrix,
//   clamp and byte packing feeding the result register. Throughput
//   is 1 item per clock while m_axis_tready stays high, set by the
//   single-pass matrix path.
// Reset (rst, synchronous): both stages empty, format back to ARGB32.
// Back-pressure: when m_axis_tready is low the result register holds;
//   the input register still takes one more item, after that
//   s_axis_tready drops until the output side drains.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_pixel_convert_top (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,      // pixel_format
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // luma, chroma_blue, chroma_red, alpha
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // pixel_word[31:0], pixel_bytes[34:32], zero pad
);
  import yrgb_pkg::*;

  `include "assert_macros.svh"

  pixel_format_t pixel_format;

  // input stage
  logic       in_valid;
  logic [7:0] in_luma;
  logic [7:0] in_cb;
  logic [7:0] in_cr;
  logic [7:0] in_alpha;

  // result stage
  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_bytes;

  logic        out_ready;
  logic        in_advance;
  logic        in_take;

  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] out_word_next;
  logic [2:0]  out_bytes_next;

  // Result register frees when empty or when being read; input stage
  // moves on whenever the result register can take it.
  assign out_ready     = !out_valid || m_axis_tready;
  assign in_advance    = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_ARGB32;
    end else if (cfg_we) begin
      pixel_format <= pixel_format_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_luma  <= s_axis_tdata[7:0];
      in_cb    <= s_axis_tdata[15:8];
      in_cr    <= s_axis_tdata[23:16];
      in_alpha <= s_axis_tdata[31:24];
    end
  end

  yrgb_matrix u_matrix (
    .luma        (in_luma),
    .chroma_blue (in_cb),
    .chroma_red  (in_cr),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  // Byte packing per format, little-endian word.
  always_comb begin
    case (pixel_format)
      FMT_ARGB32: begin
        out_word_next  = {in_alpha, red, green, blue};
        out_bytes_next = BYTES_32;
      end
      FMT_ABGR32: begin
        out_word_next  = {in_alpha, blue, green, red};
        out_bytes_next = BYTES_32;
      end
      FMT_RGB24: begin
        out_word_next  = {8'd0, red, green, blue};
        out_bytes_next = BYTES_24;
      end
      FMT_BGR24: begin
        out_word_next  = {8'd0, blue, green, red};
        out_bytes_next = BYTES_24;
      end
      default: begin
        out_word_next  = 32'd0;
        out_bytes_next = BYTES_32;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      out_word  <= out_word_next;
      out_bytes <= out_bytes_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_bytes, out_word};

  // 24-bit results never carry alpha in the top byte.
  `ASSERT_CLK_RST(a_top_byte_24, clk, rst, (out_valid && out_bytes == BYTES_24) |-> (out_word[31:24] == 8'd0))
  // Only the two legal byte counts appear.
  `ASSERT_CLK_RST(a_bytes_legal, clk, rst, out_valid |-> (out_bytes == BYTES_24 || out_bytes == BYTES_32))
  // An item leaving the input stage lands in the result register.
  `ASSERT_CLK_RST(a_advance_lands, clk, rst, in_advance |=> out_valid)
  // A stalled result is not dropped.
  `ASSERT_CLK_RST(a_stall_holds, clk, rst, (out_valid && !m_axis_tready) |=> (out_valid && $stable(out_word)))
  // Reset empties the pipe.
  `ASSERT_CLK(a_reset_empty, clk, rst |=> (!out_valid && !in_valid))

endmodule

FILE: src/yrgb_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_matrix
// BT.601 full-range color matrix: Y, Cb, Cr bytes to clamped R, G, B.
// ----------------------------------------------------------------------------
module yrgb_matrix (
  input  logic [7:0] luma,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] chroma_red,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import yrgb_pkg::*;

  logic signed [8:0]       cb_s;
  logic signed [8:0]       cr_s;
  logic signed [ACC_W-1:0] cb_x;
  logic signed [ACC_W-1:0] cr_x;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_g;
  logic signed [ACC_W-1:0] acc_b;

  // remove chroma offset
  assign cb_s = $signed({1'b0, chroma_blue} - CHROMA_OFFSET);
  assign cr_s = $signed({1'b0, chroma_red} - CHROMA_OFFSET);
  assign cb_x = ACC_W'(cb_s);
  assign cr_x = ACC_W'(cr_s);

  assign base = $signed({{(ACC_W-24){1'b0}}, luma, ROUND_HALF});

  assign acc_r = base + cr_x * ACC_W'(K_R_CR);
  assign acc_g = base - cb_x * ACC_W'(K_G_CB) - cr_x * ACC_W'(K_G_CR);
  assign acc_b = base + cb_x * ACC_W'(K_B_CB);

  assign red   = clamp_channel(acc_r);
  assign green = clamp_channel(acc_g);
  assign blue  = clamp_channel(acc_b);

endmodule
